// File: rtl/mandelbrot_escape_time_unit_defines.svh
// assertion macros for the escape time unit
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/met_pkg.sv
// shared types, constants and fixed-point helpers of the escape time unit
package met_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 24;

  localparam int PIX_W    = 12;
  localparam int CNT_W    = 16;
  localparam int Z_W      = 32;
  localparam int P_W      = 2 * Z_W;
  localparam int STEP_W   = 25;
  localparam int LIMIT_W  = 28;
  localparam int LIM2_W   = 2 * LIMIT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [Z_W-1:0]   RST_RE_LEFT   = -32'sd41943040;
  localparam logic [STEP_W-1:0]       RST_REAL_STEP = 25'd57344;
  localparam logic signed [Z_W-1:0]   RST_IMAG_MAX  = 32'sd20971520;
  localparam logic [STEP_W-1:0]       RST_IMAG_STEP = 25'd40960;
  localparam logic [LIMIT_W-1:0]      RST_LIMIT     = 28'd33554432;
  localparam logic [CNT_W-1:0]        RST_MAX_ITER  = 16'd256;

  localparam logic signed [P_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [P_W-1:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RE_LEFT   = 3'd0,
    CFG_REAL_STEP = 3'd1,
    CFG_IMAG_MAX  = 3'd2,
    CFG_IMAG_STEP = 3'd3,
    CFG_LIMIT     = 3'd4,
    CFG_MAX_ITER  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [Z_W-1:0] re_left;
    logic [STEP_W-1:0]     real_step;
    logic signed [Z_W-1:0] imag_max;
    logic [STEP_W-1:0]     imag_step;
    logic [LIMIT_W-1:0]    escape_limit;
    logic [CNT_W-1:0]      max_iter;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_MAP_R,
    ST_MAP_I,
    ST_INIT,
    ST_SQ_R,
    ST_SQ_I,
    ST_CROSS,
    ST_UPDATE,
    ST_DONE
  } met_state_t;

  function automatic logic signed [Z_W-1:0] sat32(input logic signed [P_W-1:0] v);
    logic signed [Z_W-1:0] res;
    if (v > S32_MAX) begin
      res = S32_MAX[Z_W-1:0];
    end else if (v < S32_MIN) begin
      res = S32_MIN[Z_W-1:0];
    end else begin
      res = v[Z_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] res;
    if ((PIX_W+1)'(p) >= (PIX_W+1)'(MAX_DIM)) begin
      res = PIX_W'(MAX_DIM - 1);
    end else begin
      res = p;
    end
    return res;
  endfunction

endpackage

// File: rtl/met_ifs.sv
// valid/ready channel interfaces for pixels, counts and register writes
interface met_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  modport source(output valid, pixel_x, pixel_y, input ready);
  modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

interface met_cnt_if;
  logic        valid;
  logic        ready;
  logic [15:0] escape_count;
  modport source(output valid, escape_count, input ready);
  modport sink(input valid, escape_count, output ready);
endinterface

interface met_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/met_mul.sv
// shared signed 32x32 multiplier with registered product
module met_mul (
  input  logic                             clk,
  input  logic signed [met_pkg::Z_W-1:0]   op_a,
  input  logic signed [met_pkg::Z_W-1:0]   op_b,
  output logic signed [met_pkg::P_W-1:0]   prod_r
);
  import met_pkg::*;

  logic signed [P_W-1:0] prod_nxt;

  assign prod_nxt = P_W'(op_a) * P_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: rtl/met_cfg.sv
// configuration register file
module met_cfg (
  input  logic                clk,
  input  logic                rst_n,
  met_cfg_if.sink             cfg,
  output met_pkg::cfg_regs_t  regs
);
  import met_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg.ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_RE_LEFT:   regs_nxt.re_left      = cfg.data;
        CFG_REAL_STEP: regs_nxt.real_step    = cfg.data[STEP_W-1:0];
        CFG_IMAG_MAX:  regs_nxt.imag_max     = cfg.data;
        CFG_IMAG_STEP: regs_nxt.imag_step    = cfg.data[STEP_W-1:0];
        CFG_LIMIT:     regs_nxt.escape_limit = cfg.data[LIMIT_W-1:0];
        CFG_MAX_ITER:  regs_nxt.max_iter     = cfg.data[CNT_W-1:0];
        default:       regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.re_left      <= RST_RE_LEFT;
      regs_r.real_step    <= RST_REAL_STEP;
      regs_r.imag_max     <= RST_IMAG_MAX;
      regs_r.imag_step    <= RST_IMAG_STEP;
      regs_r.escape_limit <= RST_LIMIT;
      regs_r.max_iter     <= RST_MAX_ITER;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// File: rtl/met_core.sv
// sequencer and z datapath around the shared multiplier
`include "mandelbrot_escape_time_unit_defines.svh"
module met_core (
  input  logic                            clk,
  input  logic                            rst_n,
  met_pix_if.sink                         in_px,
  met_cnt_if.source                       out_cnt,
  input  met_pkg::cfg_regs_t              regs,
  output logic signed [met_pkg::Z_W-1:0]  op_a,
  output logic signed [met_pkg::Z_W-1:0]  op_b,
  input  logic signed [met_pkg::P_W-1:0]  prod
);
  import met_pkg::*;

  met_state_t            state_r, state_nxt;
  logic [PIX_W-1:0]      px_r, px_nxt;
  logic [PIX_W-1:0]      py_r, py_nxt;
  logic [LIM2_W-1:0]     lim2_r, lim2_nxt;
  logic signed [Z_W-1:0] cr_r, cr_nxt;
  logic signed [Z_W-1:0] ci_r, ci_nxt;
  logic signed [Z_W-1:0] zr_r, zr_nxt;
  logic signed [Z_W-1:0] zi_r, zi_nxt;
  logic signed [P_W-1:0] rr_r, rr_nxt;
  logic signed [P_W-1:0] ii_r, ii_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic signed [Z_W-1:0] a2, b2, ab2;
  logic signed [Z_W-1:0] zr_upd, zi_upd;
  logic [P_W-1:0]        mag;
  logic                  escape_hit;

  // scaled squares and doubled cross term
  assign a2     = sat32(rr_r >>> FRAC_BITS);
  assign b2     = sat32(ii_r >>> FRAC_BITS);
  assign ab2    = sat32(prod >>> (FRAC_BITS - 1));
  assign zr_upd = sat32(P_W'(a2) - P_W'(b2) + P_W'(cr_r));
  assign zi_upd = sat32(P_W'(ab2) + P_W'(ci_r));

  // |z|^2 of the latest z: zr^2 held in rr_r, zi^2 on the product
  assign mag        = $unsigned(rr_r) + $unsigned(prod);
  assign escape_hit = mag > P_W'(lim2_r);

  assign in_px.ready          = (state_r == ST_IDLE);
  assign out_cnt.valid        = out_valid_r;
  assign out_cnt.escape_count = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    lim2_nxt      = lim2_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    op_a          = '0;
    op_b          = '0;

    if (out_valid_r && out_cnt.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_px.valid) begin
          px_nxt    = clamp_pix(in_px.pixel_x);
          py_nxt    = clamp_pix(in_px.pixel_y);
          state_nxt = ST_LIM;
        end
      end
      ST_LIM: begin
        op_a      = Z_W'(regs.escape_limit);
        op_b      = Z_W'(regs.escape_limit);
        state_nxt = ST_MAP_R;
      end
      ST_MAP_R: begin
        op_a      = Z_W'({px_r, 1'b1});
        op_b      = Z_W'(regs.real_step);
        lim2_nxt  = prod[LIM2_W-1:0];
        state_nxt = ST_MAP_I;
      end
      ST_MAP_I: begin
        op_a      = Z_W'({py_r, 1'b1});
        op_b      = Z_W'(regs.imag_step);
        cr_nxt    = sat32(P_W'($signed(regs.re_left)) + (prod >>> 1));
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        ci_nxt    = sat32(P_W'($signed(regs.imag_max)) - (prod >>> 1));
        zr_nxt    = '0;
        zi_nxt    = '0;
        n_nxt     = '0;
        state_nxt = ST_SQ_R;
      end
      ST_SQ_R: begin
        op_a      = zr_r;
        op_b      = zr_r;
        state_nxt = ST_SQ_I;
      end
      ST_SQ_I: begin
        op_a      = zi_r;
        op_b      = zi_r;
        rr_nxt    = prod;
        state_nxt = ST_CROSS;
      end
      ST_CROSS: begin
        op_a   = zr_r;
        op_b   = zi_r;
        ii_nxt = prod;
        priority if (escape_hit) begin
          cnt_nxt   = n_r;
          state_nxt = ST_DONE;
        end else if (n_r == regs.max_iter) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        zr_nxt    = zr_upd;
        zi_nxt    = zi_upd;
        n_nxt     = n_r + 1'b1;
        state_nxt = ST_SQ_R;
      end
      ST_DONE: begin
        if (!out_valid_r || out_cnt.ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    lim2_r    <= lim2_nxt;
    cr_r      <= cr_nxt;
    ci_r      <= ci_nxt;
    zr_r      <= zr_nxt;
    zi_r      <= zi_nxt;
    rr_r      <= rr_nxt;
    ii_r      <= ii_nxt;
    cnt_r     <= cnt_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  `MET_ASSERT_NOW(a_squares_nonneg, state_r == ST_CROSS, !rr_r[P_W-1] && !prod[P_W-1], "negative square on the escape test")
  `MET_ASSERT_NEXT(a_iter_step, state_r == ST_UPDATE, n_r == $past(n_r) + 1'b1, "iteration count did not advance by one")
  `MET_ASSERT_NOW(a_out_load, $rose(out_valid_r), $past(state_r == ST_DONE), "result word loaded outside done")

endmodule

// File: rtl/mandelbrot_escape_time_unit.sv
// top level of the mandelbrot escape time unit
// per pixel: escape limit squared, c mapped from the pixel, z cleared, then z iterated until escape or max_iter
// pixels are taken one at a time: a new one is accepted only once the last count is loaded for output
// the single shared 32x32 multiplier, used three times per iteration, limits the iteration speed
// synchronous active-low reset: idle, no pending word, registers at power-on values
module mandelbrot_escape_time_unit (
  input  logic       clk,
  input  logic       rst_n,
  met_pix_if.sink    in_px,
  met_cnt_if.source  out_cnt,
  met_cfg_if.sink    cfg_wr
);
  import met_pkg::*;

  cfg_regs_t             regs;
  logic signed [Z_W-1:0] op_a;
  logic signed [Z_W-1:0] op_b;
  logic signed [P_W-1:0] prod;

  met_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .regs  (regs)
  );

  met_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  met_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (in_px),
    .out_cnt (out_cnt),
    .regs    (regs),
    .op_a    (op_a),
    .op_b    (op_b),
    .prod    (prod)
  );

endmodule
